[src/itcf_pkg.sv]
// Shared types, widths and constants for the IMU tilt complementary filter.
`default_nettype none
package itcf_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int ANGLE_FRAC_BITS   = 16;
   localparam int TABLE_LEN         = 24;
   localparam int PRESCALE_SH       = 16;

   localparam int X_W     = 36;
   localparam int Z_W     = 42;
   localparam int SH_W    = 5;
   localparam int TILT_W  = Z_W - 32 + ANGLE_FRAC_BITS;
   localparam int LIM_W   = ANGLE_FRAC_BITS + 8;
   localparam int CMP_W   = (LIM_W + 1 > 33) ? LIM_W + 1 : 33;
   localparam int MA_W0   = (TILT_W > 33) ? TILT_W : 33;
   localparam int MA_W    = (MA_W0 > LIM_W + 1) ? MA_W0 : LIM_W + 1;
   localparam int MB_W    = 25;
   localparam int P_W     = MA_W + MB_W;
   localparam int SUM_W   = P_W + 2;
   localparam int GYRO_SH = 32 - ANGLE_FRAC_BITS;
   localparam int BYTE_SH = ANGLE_FRAC_BITS + 8;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_BLEND_ALPHA = 2'd0;
   localparam logic [1:0] REG_GYRO_GAIN   = 2'd1;
   localparam logic [1:0] REG_CLAMP_LIMIT = 2'd2;
   localparam logic [1:0] REG_MAP_GAIN    = 2'd3;

   localparam logic [16:0] ALPHA_RESET = 17'd1311;
   localparam logic [23:0] GAIN_RESET  = 24'd654721;
   localparam logic [7:0]  LIMIT_RESET = 8'd45;
   localparam logic [11:0] MAP_RESET   = 12'd722;

   typedef logic signed [X_W-1:0]    x_type;
   typedef logic signed [Z_W-1:0]    z_type;
   typedef logic signed [TILT_W-1:0] tilt_type;
   typedef logic signed [CMP_W-1:0]  cmp_type;
   typedef logic signed [MA_W-1:0]   ma_type;
   typedef logic signed [MB_W-1:0]   mb_type;
   typedef logic signed [P_W-1:0]    p_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef struct packed {
      logic                  zero;
      logic signed [X_W-1:0] x;
      logic signed [X_W-1:0] y;
      logic signed [Z_W-1:0] z;
   } lane_type;

   typedef struct packed {
      logic     valid;
      lane_type pitch;
      lane_type roll;
   } stage_type;

   // Arctangent of 2^-i in degrees, Q.32
   function automatic z_type atan_q32(input logic [SH_W-1:0] idx);
      z_type r;
      case (idx)
         5'd0:    r = 42'sd193273528320;
         5'd1:    r = 42'sd114096026022;
         5'd2:    r = 42'sd60285206653;
         5'd3:    r = 42'sd30601712202;
         5'd4:    r = 42'sd15360239180;
         5'd5:    r = 42'sd7687607525;
         5'd6:    r = 42'sd3844741809;
         5'd7:    r = 42'sd1922488224;
         5'd8:    r = 42'sd961258780;
         5'd9:    r = 42'sd480631223;
         5'd10:   r = 42'sd240315841;
         5'd11:   r = 42'sd120157949;
         5'd12:   r = 42'sd60078978;
         5'd13:   r = 42'sd30039490;
         5'd14:   r = 42'sd15019745;
         5'd15:   r = 42'sd7509872;
         5'd16:   r = 42'sd3754936;
         5'd17:   r = 42'sd1877468;
         5'd18:   r = 42'sd938734;
         5'd19:   r = 42'sd469367;
         5'd20:   r = 42'sd234684;
         5'd21:   r = 42'sd117342;
         5'd22:   r = 42'sd58671;
         5'd23:   r = 42'sd29335;
         default: r = '0;
      endcase
      return r;
   endfunction

   // One vectoring rotation; shifts floor toward minus infinity
   function automatic lane_type cordic_turn(input lane_type l, input logic [SH_W-1:0] sh,
                                            input z_type atan);
      x_type    x;
      x_type    y;
      x_type    dx;
      x_type    dy;
      lane_type r;
      x  = l.x;
      y  = l.y;
      dx = y >>> sh;
      dy = x >>> sh;
      r.zero = l.zero;
      if (!y[X_W-1]) begin
         r.x = x + dx;
         r.y = y - dy;
         r.z = l.z + atan;
      end else begin
         r.x = x - dx;
         r.y = y + dy;
         r.z = l.z - atan;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input sum_type v);
      logic signed [31:0] r;
      if (v > sum_type'(33'sh0_7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < sum_type'(-33'sh0_8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[src/itcf_cell.sv]
// One CORDIC cell: a single rotation step for the pitch and roll vectors.
`default_nettype none
module itcf_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [itcf_pkg::SH_W-1:0]    cell_shift,
   input  wire itcf_pkg::z_type              cell_atan,
   input  wire itcf_pkg::stage_type          stage_in,
   output itcf_pkg::stage_type               stage_out
);

   logic                 valid_ff;
   itcf_pkg::lane_type   pitch_ff;
   itcf_pkg::lane_type   roll_ff;
   itcf_pkg::lane_type   pitch_in;
   itcf_pkg::lane_type   roll_in;

   always_comb begin
      pitch_in = itcf_pkg::cordic_turn(stage_in.pitch, cell_shift, cell_atan);
      roll_in  = itcf_pkg::cordic_turn(stage_in.roll, cell_shift, cell_atan);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
      pitch_ff <= pitch_in;
      roll_ff  <= roll_in;
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.pitch = pitch_ff;
   assign stage_out.roll  = roll_ff;

endmodule
`default_nettype wire

[src/itcf_chain.sv]
// Row of CORDIC cells with input pre-rotation and output rounding to degrees.
`default_nettype none
module itcf_chain (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic signed [15:0]    accel_x,
   input  wire logic signed [15:0]    accel_y,
   input  wire logic signed [15:0]    accel_z,
   output logic                       tilt_done,
   output itcf_pkg::tilt_type         tilt_pitch,
   output itcf_pkg::tilt_type         tilt_roll
);

   itcf_pkg::stage_type link [0:itcf_pkg::CORDIC_ITERATIONS];

   logic                done_ff;
   itcf_pkg::tilt_type  tilt_pitch_ff;
   itcf_pkg::tilt_type  tilt_roll_ff;
   itcf_pkg::tilt_type  tilt_pitch_in;
   itcf_pkg::tilt_type  tilt_roll_in;

   // Start vector; turn by 180 degrees when the denominator is negative
   function automatic itcf_pkg::lane_type feed(input logic signed [15:0] num,
                                               input logic signed [15:0] den);
      itcf_pkg::lane_type r;
      itcf_pkg::x_type    x;
      itcf_pkg::x_type    y;
      x = itcf_pkg::x_type'(den) <<< itcf_pkg::PRESCALE_SH;
      y = itcf_pkg::x_type'(num) <<< itcf_pkg::PRESCALE_SH;
      r.zero = (num == 16'sd0) && (den == 16'sd0);
      if (den[15]) begin
         r.x = -x;
         r.y = -y;
         r.z = num[15] ? (-(itcf_pkg::z_type'(180) <<< 32))
                       : (itcf_pkg::z_type'(180) <<< 32);
      end else begin
         r.x = x;
         r.y = y;
         r.z = '0;
      end
      return r;
   endfunction

   function automatic itcf_pkg::tilt_type round_deg(input itcf_pkg::lane_type l);
      itcf_pkg::z_type z;
      z = (l.z + (itcf_pkg::z_type'(1) <<< (31 - itcf_pkg::ANGLE_FRAC_BITS)))
          >>> itcf_pkg::GYRO_SH;
      return l.zero ? '0 : z[itcf_pkg::TILT_W-1:0];
   endfunction

   assign link[0].valid = start;
   assign link[0].pitch = feed(accel_y, accel_z);
   assign link[0].roll  = feed(accel_x, accel_z);

   for (genvar i = 0; i < itcf_pkg::CORDIC_ITERATIONS; i++) begin : g_cell
      itcf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_shift (itcf_pkg::SH_W'(i)),
         .cell_atan  (itcf_pkg::atan_q32(itcf_pkg::SH_W'(i))),
         .stage_in   (link[i]),
         .stage_out  (link[i+1])
      );
   end

   always_comb begin
      tilt_pitch_in = round_deg(link[itcf_pkg::CORDIC_ITERATIONS].pitch);
      tilt_roll_in  = round_deg(link[itcf_pkg::CORDIC_ITERATIONS].roll);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= link[itcf_pkg::CORDIC_ITERATIONS].valid;
      end
      // hold the tilts until the next item leaves the row
      if (link[itcf_pkg::CORDIC_ITERATIONS].valid) begin
         tilt_pitch_ff <= tilt_pitch_in;
         tilt_roll_ff  <= tilt_roll_in;
      end
   end

   assign tilt_done  = done_ff;
   assign tilt_pitch = tilt_pitch_ff;
   assign tilt_roll  = tilt_roll_ff;

endmodule
`default_nettype wire

[src/imu_tilt_complementary_filter.sv]
// Top level: gyro integration, accelerometer blend and byte mapping around the CORDIC row.
//
// Usage:
//   req channel: one sample set per transfer. req_tdata holds accel_x, accel_y,
//   accel_z, gyro_x and gyro_y, 16 bits each, lowest bits first.
//   rsp channel: one result per sample set: pitch_deg and roll_deg (Q16.16
//   degrees) then pitch_byte and roll_byte.
//   csr port: write csr_wdata to register csr_index when csr_we is high;
//   0 blend_alpha, 1 gyro_step_gain, 2 clamp_limit_deg, 3 map_gain. Write only
//   while the block is idle.
// Timing: one item at a time. The vector passes the 16 CORDIC cells and the
//   tilt register before the blend starts; a single shared multiplier then does
//   the two blends (states BP1-BP3 and BR1-BR3) and the two byte maps (MP, MR,
//   MX), and the output state loads the rsp register, after which the block
//   returns to idle and takes the next item.
// Reset: both angles clear to zero and the registers take their defaults.
// Stall: the result waits in the rsp output register; a new item may be taken
//   meanwhile, and its result waits until the held one is transferred.
`default_nettype none
module imu_tilt_complementary_filter (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [79:0]  req_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [79:0]       rsp_tdata,   // pitch_deg, roll_deg, pitch_byte, roll_byte
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [23:0]  csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_GX, ST_GY, ST_GR, ST_WAIT,
      ST_BP1, ST_BP2, ST_BP3, ST_BR1, ST_BR2, ST_BR3,
      ST_MP, ST_MR, ST_MX, ST_OUT
   } state_type;

   state_type           state_ff;
   logic [16:0]         alpha_ff;
   logic [23:0]         gain_ff;
   logic [7:0]          limit_ff;
   logic [11:0]         map_ff;
   logic signed [15:0]  gyro_x_ff;
   logic signed [15:0]  gyro_y_ff;
   logic signed [31:0]  pitch_ff;
   logic signed [31:0]  roll_ff;
   itcf_pkg::p_type     prod_ff;
   itcf_pkg::p_type     acc_ff;
   logic                neg_ff;
   logic [7:0]          pitch_byte_ff;
   logic [7:0]          roll_byte_ff;
   logic                rsp_valid_ff;
   logic [79:0]         rsp_data_ff;

   logic                 accept;
   logic                 tilt_done;
   itcf_pkg::tilt_type   tilt_pitch;
   itcf_pkg::tilt_type   tilt_roll;
   itcf_pkg::ma_type     mul_a;
   itcf_pkg::mb_type     mul_b;
   itcf_pkg::p_type      prod_in;
   logic [16:0]          alpha_c;
   logic [16:0]          alpha_inv;
   logic signed [31:0]   map_ang;
   itcf_pkg::cmp_type    ang_c;
   itcf_pkg::cmp_type    lim_c;
   itcf_pkg::cmp_type    clip;
   itcf_pkg::cmp_type    clip_abs;
   logic                 neg_in;
   logic [itcf_pkg::LIM_W-1:0] mag;
   itcf_pkg::p_type      gyro_step;
   itcf_pkg::sum_type    blend_sum;
   logic signed [31:0]   pitch_gyro_in;
   logic signed [31:0]   roll_gyro_in;
   logic signed [31:0]   blend_in;
   logic [7:0]           byte_in;
   itcf_pkg::p_type      byte_mag;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   itcf_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .accel_x    (req_tdata[15:0]),
      .accel_y    (req_tdata[31:16]),
      .accel_z    (req_tdata[47:32]),
      .tilt_done  (tilt_done),
      .tilt_pitch (tilt_pitch),
      .tilt_roll  (tilt_roll)
   );

   // Alpha above one counts as one
   assign alpha_c   = alpha_ff[16] ? 17'h10000 : alpha_ff;
   assign alpha_inv = 17'h10000 - alpha_c;

   // Clamp unit for the byte map, shared by both angles
   always_comb begin
      map_ang  = (state_ff == ST_MP) ? pitch_ff : roll_ff;
      ang_c    = itcf_pkg::cmp_type'(map_ang);
      lim_c    = itcf_pkg::cmp_type'({limit_ff, {itcf_pkg::ANGLE_FRAC_BITS{1'b0}}});
      if (ang_c > lim_c) begin
         clip = lim_c;
      end else if (ang_c < -lim_c) begin
         clip = -lim_c;
      end else begin
         clip = ang_c;
      end
      neg_in   = clip[itcf_pkg::CMP_W-1];
      clip_abs = neg_in ? -clip : clip;
      mag      = clip_abs[itcf_pkg::LIM_W-1:0];
   end

   // Shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_GX: begin
            mul_a = itcf_pkg::ma_type'(gyro_x_ff);
            mul_b = itcf_pkg::mb_type'(gain_ff);
         end
         ST_GY: begin
            mul_a = itcf_pkg::ma_type'(gyro_y_ff);
            mul_b = itcf_pkg::mb_type'(gain_ff);
         end
         ST_BP1: begin
            mul_a = itcf_pkg::ma_type'(pitch_ff);
            mul_b = itcf_pkg::mb_type'(alpha_inv);
         end
         ST_BP2: begin
            mul_a = itcf_pkg::ma_type'(tilt_pitch);
            mul_b = itcf_pkg::mb_type'(alpha_c);
         end
         ST_BR1: begin
            mul_a = itcf_pkg::ma_type'(roll_ff);
            mul_b = itcf_pkg::mb_type'(alpha_inv);
         end
         ST_BR2: begin
            mul_a = itcf_pkg::ma_type'(tilt_roll);
            mul_b = itcf_pkg::mb_type'(alpha_c);
         end
         ST_MP, ST_MR: begin
            mul_a = itcf_pkg::ma_type'(mag);
            mul_b = itcf_pkg::mb_type'(map_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = itcf_pkg::p_type'(mul_a) * itcf_pkg::p_type'(mul_b);
   end

   // Result arithmetic on the registered product
   always_comb begin
      gyro_step     = prod_ff >>> itcf_pkg::GYRO_SH;
      pitch_gyro_in = itcf_pkg::sat32(itcf_pkg::sum_type'(pitch_ff)
                                      + itcf_pkg::sum_type'(gyro_step));
      roll_gyro_in  = itcf_pkg::sat32(itcf_pkg::sum_type'(roll_ff)
                                      - itcf_pkg::sum_type'(gyro_step));
      blend_sum     = (itcf_pkg::sum_type'(acc_ff) + itcf_pkg::sum_type'(prod_ff)
                       + itcf_pkg::sum_type'(32768)) >>> 16;
      blend_in      = itcf_pkg::sat32(blend_sum);
      byte_mag      = prod_ff >>> itcf_pkg::BYTE_SH;
      if (byte_mag > itcf_pkg::p_type'(127)) begin
         byte_in = 8'd127;
      end else begin
         byte_in = {1'b0, byte_mag[6:0]};
      end
      if (neg_ff) begin
         byte_in = -byte_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= itcf_pkg::ALPHA_RESET;
         gain_ff  <= itcf_pkg::GAIN_RESET;
         limit_ff <= itcf_pkg::LIMIT_RESET;
         map_ff   <= itcf_pkg::MAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            itcf_pkg::REG_BLEND_ALPHA: alpha_ff <= csr_wdata[16:0];
            itcf_pkg::REG_GYRO_GAIN:   gain_ff  <= csr_wdata;
            itcf_pkg::REG_CLAMP_LIMIT: limit_ff <= csr_wdata[7:0];
            itcf_pkg::REG_MAP_GAIN:    map_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Sequencer with angle state and the result register
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         pitch_ff     <= '0;
         roll_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the output state reloads the register itself on a transfer
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  gyro_x_ff <= req_tdata[63:48];
                  gyro_y_ff <= req_tdata[79:64];
                  state_ff  <= ST_GX;
               end
            end
            ST_GX: state_ff <= ST_GY;
            ST_GY: begin
               pitch_ff <= pitch_gyro_in;
               state_ff <= ST_GR;
            end
            ST_GR: begin
               roll_ff  <= roll_gyro_in;
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (tilt_done) begin
                  state_ff <= ST_BP1;
               end
            end
            ST_BP1: state_ff <= ST_BP2;
            ST_BP2: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_BP3;
            end
            ST_BP3: begin
               pitch_ff <= blend_in;
               state_ff <= ST_BR1;
            end
            ST_BR1: state_ff <= ST_BR2;
            ST_BR2: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_BR3;
            end
            ST_BR3: begin
               roll_ff  <= blend_in;
               state_ff <= ST_MP;
            end
            ST_MP: begin
               neg_ff   <= neg_in;
               state_ff <= ST_MR;
            end
            ST_MR: begin
               pitch_byte_ff <= byte_in;
               neg_ff        <= neg_in;
               state_ff      <= ST_MX;
            end
            ST_MX: begin
               roll_byte_ff <= byte_in;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               // hold until the previous result is transferred
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {roll_byte_ff, pitch_byte_ff, roll_ff, pitch_ff};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

[tb/tb_imu_tilt_complementary_filter.sv]
// Self-checking testbench for the IMU tilt complementary filter: predicts each angle pair and byte pair.
`default_nettype none
module tb_imu_tilt_complementary_filter;
   timeunit 1ns;
   timeprecision 1ps;

   // fields from the lowest bit up: accel_x, accel_y, accel_z, gyro_x, gyro_y
   typedef struct packed {
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_x;
      logic signed [15:0] accel_z;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_x;
   } imu_sample_type;

   // fields from the lowest bit up: pitch_deg, roll_deg, pitch_byte, roll_byte
   typedef struct packed {
      logic signed [7:0]  roll_byte;
      logic signed [7:0]  pitch_byte;
      logic signed [31:0] roll_deg;
      logic signed [31:0] pitch_deg;
   } tilt_result_type;

   // arctangent of 2^-i in degrees, Q.32
   localparam longint ATAN_Q32 [itcf_pkg::TABLE_LEN] = '{
      64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
      64'sd15360239180, 64'sd7687607525, 64'sd3844741809, 64'sd1922488224,
      64'sd961258780, 64'sd480631223, 64'sd240315841, 64'sd120157949,
      64'sd60078978, 64'sd30039490, 64'sd15019745, 64'sd7509872,
      64'sd3754936, 64'sd1877468, 64'sd938734, 64'sd469367,
      64'sd234684, 64'sd117342, 64'sd58671, 64'sd29335
   };

   class tilt_tracker;
      int              pitch_q;
      int              roll_q;
      longint          alpha;
      longint          step_gain;
      longint          limit_deg;
      longint          byte_gain;
      tilt_result_type awaited[$];
      int              errors;

      function new();
         pitch_q   = 0;
         roll_q    = 0;
         alpha     = itcf_pkg::ALPHA_RESET;
         step_gain = itcf_pkg::GAIN_RESET;
         limit_deg = itcf_pkg::LIMIT_RESET;
         byte_gain = itcf_pkg::MAP_RESET;
         errors    = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [23:0] val);
         case (idx)
            itcf_pkg::REG_BLEND_ALPHA: alpha     = val[16:0];
            itcf_pkg::REG_GYRO_GAIN:   step_gain = val[23:0];
            itcf_pkg::REG_CLAMP_LIMIT: limit_deg = val[7:0];
            itcf_pkg::REG_MAP_GAIN:    byte_gain = val[11:0];
            default: ;
         endcase
      endfunction

      function int clip32(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'sh8000_0000;
         return int'(v);
      endfunction

      // atan2(num, den) in degrees with ANGLE_FRAC_BITS fraction bits
      function longint tilt(longint num, longint den);
         longint x;
         longint y;
         longint z;
         longint dx;
         longint dy;
         if (num == 0 && den == 0) return 0;
         x = den * 65536;
         y = num * 65536;
         z = 0;
         if (den < 0) begin
            // turn by half a circle, landing on the side of the numerator sign
            z = (num >= 0) ? (longint'(180) <<< 32) : -(longint'(180) <<< 32);
            x = -x;
            y = -y;
         end
         for (int i = 0; i < itcf_pkg::CORDIC_ITERATIONS && i < itcf_pkg::TABLE_LEN; i++)
         begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               z = z + ATAN_Q32[i];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - ATAN_Q32[i];
            end
         end
         return (z + (longint'(1) <<< (31 - itcf_pkg::ANGLE_FRAC_BITS)))
                >>> (32 - itcf_pkg::ANGLE_FRAC_BITS);
      endfunction

      function int mix(int ang, longint acc);
         longint a;
         a = (alpha > 65536) ? 65536 : alpha;
         return clip32((longint'(ang) * (65536 - a) + acc * a + 32768) >>> 16);
      endfunction

      function logic [7:0] to_byte(int ang);
         longint lim;
         longint c;
         longint mag;
         lim = limit_deg <<< itcf_pkg::ANGLE_FRAC_BITS;
         c   = ang;
         if (c > lim) c = lim;
         if (c < -lim) c = -lim;
         mag = (c < 0) ? -c : c;
         mag = (mag * byte_gain) >>> (itcf_pkg::ANGLE_FRAC_BITS + 8);
         if (mag > 127) mag = 127;
         if (c < 0) mag = -mag;
         return mag[7:0];
      endfunction

      function void take_sample(imu_sample_type s);
         tilt_result_type r;
         longint          dp;
         longint          dr;
         dp = (longint'(s.gyro_x) * step_gain) >>> (32 - itcf_pkg::ANGLE_FRAC_BITS);
         dr = (longint'(s.gyro_y) * step_gain) >>> (32 - itcf_pkg::ANGLE_FRAC_BITS);
         pitch_q = clip32(longint'(pitch_q) + dp);
         roll_q  = clip32(longint'(roll_q) - dr);
         pitch_q = mix(pitch_q, tilt(s.accel_y, s.accel_z));
         roll_q  = mix(roll_q, tilt(s.accel_x, s.accel_z));
         r.pitch_deg  = pitch_q;
         r.roll_deg   = roll_q;
         r.pitch_byte = to_byte(pitch_q);
         r.roll_byte  = to_byte(roll_q);
         awaited.push_back(r);
      endfunction

      function void match_result(tilt_result_type got);
         tilt_result_type want;
         if (awaited.size() == 0) begin
            $error("result with no sample pending: %h", got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.pitch_deg !== want.pitch_deg) begin
            $error("pitch_deg: expected %0d, actual %0d", want.pitch_deg, got.pitch_deg);
            errors++;
         end
         if (got.roll_deg !== want.roll_deg) begin
            $error("roll_deg: expected %0d, actual %0d", want.roll_deg, got.roll_deg);
            errors++;
         end
         if (got.pitch_byte !== want.pitch_byte) begin
            $error("pitch_byte: expected %0d, actual %0d", want.pitch_byte, got.pitch_byte);
            errors++;
         end
         if (got.roll_byte !== want.roll_byte) begin
            $error("roll_byte: expected %0d, actual %0d", want.roll_byte, got.roll_byte);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;   // accel_x, accel_y, accel_z, gyro_x, gyro_y
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;       // pitch_deg, roll_deg, pitch_byte, roll_byte
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [23:0]  csr_wdata = '0;

   int           idle_pct = 0;
   int           stall_pct = 0;
   tilt_tracker  tracker = new();

   imu_tilt_complementary_filter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.match_result(rsp_tdata);
   end

   initial begin
      #5ms;
      $display("imu_tilt_complementary_filter test failed");
      $finish;
   end

   function automatic imu_sample_type mk(int ax, int ay, int az, int gx, int gy);
      imu_sample_type s;
      s.accel_x = ax[15:0];
      s.accel_y = ay[15:0];
      s.accel_z = az[15:0];
      s.gyro_x  = gx[15:0];
      s.gyro_y  = gy[15:0];
      return s;
   endfunction

   function automatic logic [15:0] rand_axis();
      logic [15:0] v;
      case ($urandom_range(9))
         0: v = 16'h0000;
         1: v = 16'h8000;
         2: v = 16'h7FFF;
         3: v = 16'($urandom_range(64)) - 16'd32;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   // hold valid high across back-to-back transfers; drop it only in a gap
   task automatic send_sample(imu_sample_type s);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_sample(s);
   endtask

   // stop sending and wait until every pending result has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      tracker.write_reg(idx, val);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic configure(logic [23:0] alpha, logic [23:0] gain, logic [23:0] limit,
                            logic [23:0] gain_map);
      drain();
      write_csr(itcf_pkg::REG_BLEND_ALPHA, alpha);
      write_csr(itcf_pkg::REG_GYRO_GAIN, gain);
      write_csr(itcf_pkg::REG_CLAMP_LIMIT, limit);
      write_csr(itcf_pkg::REG_MAP_GAIN, gain_map);
   endtask

   // drift pushes both gyros hard one way so the angles run into saturation
   task automatic send_random(int count, bit drift);
      imu_sample_type s;
      for (int n = 0; n < count; n++) begin
         s.accel_x = rand_axis();
         s.accel_y = rand_axis();
         s.accel_z = rand_axis();
         s.gyro_x  = rand_axis();
         s.gyro_y  = rand_axis();
         if ($urandom_range(19) == 0) begin
            s.accel_y = '0;
            s.accel_z = '0;
         end
         if (drift && $urandom_range(9) != 0) begin
            s.gyro_x = 16'($urandom_range(32767, 30000));
            s.gyro_y = 16'($urandom_range(32767, 30000));
         end
         send_sample(s);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes and the tilt corner cases at default settings
      send_sample(mk(0, 0, 0, 0, 0));
      send_sample(mk(-32768, -32768, -32768, -32768, -32768));
      send_sample(mk(32767, 32767, 32767, 32767, 32767));
      send_sample(mk(0, 0, -1000, 0, 0));
      send_sample(mk(100, -100, -1000, 5, -5));
      send_sample(mk(-100, 100, -1, -5, 5));
      send_sample(mk(300, -300, 0, 0, 0));
      send_sample(mk(-300, 300, 0, 0, 0));
      send_sample(mk(0, 500, 1, 100, 100));
      send_sample(mk(32767, -32768, 1, 32767, -32768));
      send_sample(mk(-32768, 32767, -32768, -32768, 32767));
      send_sample(mk(1, 1, 32767, 1, -1));
      send_sample(mk(-1, -1, -1, -1, -1));
      send_sample(mk(12000, -8000, 16000, 200, -150));

      // gyro only, full gain: run both angles into saturation
      configure(24'd0, 24'hFF_FFFF, 24'd255, 24'd4095);
      idle_pct  = 18;
      stall_pct = 18;
      send_random(280, 1'b1);

      // weight above one: accelerometer only, zero clamp
      configure(24'd131071, 24'($urandom), 24'd0, 24'($urandom));
      idle_pct  = 82;
      stall_pct = 0;
      send_random(60, 1'b0);

      configure(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
      idle_pct  = 0;
      stall_pct = 82;
      send_random(60, 1'b0);
      drain();
      send_random(60, 1'b0);

      configure(24'($urandom_range(4000)), 24'($urandom), 24'($urandom_range(180)),
                24'($urandom));
      idle_pct  = 18;
      stall_pct = 18;
      send_random(120, 1'b0);

      configure(24'd65536, 24'd0, 24'd180, 24'd0);
      idle_pct  = 0;
      stall_pct = 0;
      send_random(30, 1'b0);
      configure(24'd1311, 24'd654721, 24'd180, 24'd4095);
      send_random(30, 1'b0);

      drain();
      repeat (40) @(posedge clock);
      if (tracker.awaited.size() != 0)
         $error("%0d results never arrived", tracker.awaited.size());
      if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
         $display("imu_tilt_complementary_filter test passed");
      end else begin
         $display("imu_tilt_complementary_filter test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
